>>> rtl/core/mtt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mtt_pkg: shared types and constants of the timer table
// Command codes, internal operation codes, result status codes and the
// queue entry carried from the front end to the execution engine.
// ============================================================================
package mtt_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int CMD_W          = 2;
    localparam int DUR_W          = 16;
    localparam int TAG_W          = 32;
    localparam int SLOT_NUM_W     = 6;
    localparam int SLOT_W         = 5;
    localparam int STATUS_W       = 3;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 40;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_CANCEL,
        OP_TICK,
        OP_REJECT
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_ACTIVE = 3'd3,
        ST_EXPIRED    = 3'd4,
        ST_TICK_DONE  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_REPLY,
        ENG_SCAN,
        ENG_TICK_RD,
        ENG_TICK_EV,
        ENG_TICK_END
    } eng_state_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_NUM_W-1:0] num;
        logic [DUR_W-1:0]      duration;
        logic [TAG_W-1:0]      tag;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } res_t;

endpackage

>>> rtl/core/mtt_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mtt_front: input decode and command queue
// Accepts input beats, sorts each into start, cancel, tick or reject and
// holds them in a two-entry queue for the engine.
// ============================================================================
module mtt_front
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // duration, user_tag, slot_number, pad
    input  logic [CMD_W-1:0]     s_tuser,   // cmd
    output logic                 q_valid,
    output cmd_t                 q_entry,
    input  logic                 q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    cmd_t             in_cmd;

    always_comb
    begin
        in_cmd.duration = s_tdata[DUR_W-1:0];
        in_cmd.tag      = s_tdata[DUR_W+TAG_W-1:DUR_W];
        in_cmd.num      = s_tdata[DUR_W+TAG_W+SLOT_NUM_W-1:DUR_W+TAG_W];
        case (cmd_code_t'(s_tuser))
            CMD_START:
            begin
                in_cmd.op = (in_cmd.duration == '0) ? OP_REJECT : OP_START;
            end
            CMD_CANCEL:
            begin
                in_cmd.op = (in_cmd.num >= SLOT_NUM_W'(NUM_TIMERS)) ? OP_REJECT : OP_CANCEL;
            end
            CMD_TICK:
            begin
                in_cmd.op = OP_TICK;
            end
            default:
            begin
                in_cmd.op = OP_REJECT;
            end
        endcase
    end

    assign s_tready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = (PTR_W+1)'(count_reg + 1'b1);
        end
        else if (!push && q_pop)
        begin
            count_next = (PTR_W+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/core/mtt_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// mtt_engine: timer table execution engine
// Pops commands, walks the slot table one slot per step and drives the
// result register. Counts and tags live in single-port memories.
// ============================================================================
module mtt_engine
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_entry,
    output logic q_pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    eng_state_t       state_reg;
    eng_state_t       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    cmd_t             cur_reg;
    logic [NUM_TIMERS-1:0] active_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;

    logic [DUR_W-1:0] rem_mem [NUM_TIMERS];
    logic [TAG_W-1:0] tag_mem [NUM_TIMERS];
    logic [DUR_W-1:0] rem_rd_reg;
    logic [TAG_W-1:0] tag_rd_reg;

    logic             can_emit;
    logic             emit;
    res_t             res_next;
    logic             act_set;
    logic             act_clr;
    logic [IDX_W-1:0] act_addr;
    logic             rem_we;
    logic [DUR_W-1:0] rem_wdata;
    logic             tag_we;
    logic             slot_busy;
    logic             is_last;
    logic             expiring;
    logic [IDX_W-1:0] cur_idx;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] i);
        logic [SLOT_NUM_W-1:0] wide;
        wide = SLOT_NUM_W'(i);
        return wide[SLOT_W-1:0];
    endfunction

    assign can_emit  = !out_valid_reg || out_ready;
    assign slot_busy = active_reg[idx_reg];
    assign is_last   = (idx_reg == IDX_W'(NUM_TIMERS - 1));
    assign expiring  = (rem_rd_reg == DUR_W'(1));
    assign cur_idx   = cur_reg.num[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_entry.op == OP_START)
                    begin
                        state_next = ENG_SCAN;
                    end
                    else if (q_entry.op == OP_TICK)
                    begin
                        state_next = ENG_TICK_RD;
                    end
                    else
                    begin
                        state_next = ENG_REPLY;
                    end
                end
            end
            ENG_REPLY:
            begin
                if (can_emit)
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_SCAN:
            begin
                if ((!slot_busy || is_last) && can_emit)
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_TICK_RD:
            begin
                if (slot_busy)
                begin
                    state_next = ENG_TICK_EV;
                end
                else if (is_last)
                begin
                    state_next = ENG_TICK_END;
                end
            end
            ENG_TICK_EV:
            begin
                if (!expiring || can_emit)
                begin
                    state_next = is_last ? ENG_TICK_END : ENG_TICK_RD;
                end
            end
            ENG_TICK_END:
            begin
                if (can_emit)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        res_next  = '0;
        idx_next  = idx_reg;
        act_set   = 1'b0;
        act_clr   = 1'b0;
        act_addr  = idx_reg;
        rem_we    = 1'b0;
        rem_wdata = cur_reg.duration;
        tag_we    = 1'b0;
        case (state_reg)
            ENG_IDLE:
            begin
                q_pop    = q_valid;
                idx_next = '0;
            end
            ENG_REPLY:
            begin
                if (can_emit)
                begin
                    emit          = 1'b1;
                    res_next.last = 1'b1;
                    if (cur_reg.op == OP_CANCEL)
                    begin
                        if (active_reg[cur_idx])
                        begin
                            res_next.status = ST_OK;
                            res_next.slot   = slot_of(cur_idx);
                            act_clr         = 1'b1;
                            act_addr        = cur_idx;
                        end
                        else
                        begin
                            res_next.status = ST_NOT_ACTIVE;
                        end
                    end
                    else
                    begin
                        res_next.status = ST_INVALID;
                    end
                end
            end
            ENG_SCAN:
            begin
                if (!slot_busy)
                begin
                    if (can_emit)
                    begin
                        emit            = 1'b1;
                        res_next.status = ST_OK;
                        res_next.slot   = slot_of(idx_reg);
                        res_next.last   = 1'b1;
                        act_set         = 1'b1;
                        rem_we          = 1'b1;
                        tag_we          = 1'b1;
                    end
                end
                else if (is_last)
                begin
                    if (can_emit)
                    begin
                        emit            = 1'b1;
                        res_next.status = ST_FULL;
                        res_next.last   = 1'b1;
                    end
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            ENG_TICK_RD:
            begin
                if (!slot_busy && !is_last)
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            ENG_TICK_EV:
            begin
                if (expiring)
                begin
                    if (can_emit)
                    begin
                        emit            = 1'b1;
                        res_next.status = ST_EXPIRED;
                        res_next.slot   = slot_of(idx_reg);
                        res_next.tag    = tag_rd_reg;
                        act_clr         = 1'b1;
                        if (!is_last)
                        begin
                            idx_next = IDX_W'(idx_reg + 1'b1);
                        end
                    end
                end
                else
                begin
                    rem_we    = 1'b1;
                    rem_wdata = DUR_W'(rem_rd_reg - 1'b1);
                    if (!is_last)
                    begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end
            ENG_TICK_END:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    res_next.status = ST_TICK_DONE;
                    res_next.last   = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            idx_reg       <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (act_set)
            begin
                active_reg[act_addr] <= 1'b1;
            end
            else if (act_clr)
            begin
                active_reg[act_addr] <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
        if (emit)
        begin
            out_res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[idx_reg] <= rem_wdata;
        end
        rem_rd_reg <= rem_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[idx_reg] <= cur_reg.tag;
        end
        tag_rd_reg <= tag_mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("result written over a held beat");

    a_ev_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_TICK_EV) |-> active_reg[idx_reg])
        else $error("tick evaluates a free slot");

    a_ev_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_TICK_EV) |-> (rem_rd_reg != '0))
        else $error("active timer holds a zero count");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (res_next.last == (res_next.status != ST_EXPIRED)))
        else $error("last flag does not match status");

    a_start_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ENG_SCAN && emit && res_next.status == ST_OK)
        |=> active_reg[$past(idx_reg)])
        else $error("started slot not marked active");

endmodule

>>> rtl/core/multi_timer_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_timer_table_core: table of one-shot countdown timers
// Start, cancel and tick commands against a table of NUM_TIMERS slots.
//
//   Port group  Dir  Beat contents
//   s_*         in   tuser: cmd; tdata: duration, user_tag, slot_number
//   m_*         out  tuser: status; tdata: slot, tag_out; tlast: last
//
// Start: scans the slots in turn up to the lowest free one, at most
// NUM_TIMERS. Cancel or reject: a single reply state. Tick: a read state
// for every slot, an evaluate state per active slot (count memory read,
// then update) and a done beat; each command is first popped from the queue.
// Reset clears all active flags at once; no clearing pass.
// A two-entry queue takes input while the engine works; a result register
// holds an output beat while the engine computes the next one.
// ============================================================================
module multi_timer_table_core
    import mtt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // duration, user_tag, slot_number, pad
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // slot, tag_out, pad
    output logic [STATUS_W-1:0]   m_tuser,   // status
    output logic                  m_tlast
);

    logic q_valid;
    cmd_t q_entry;
    logic q_pop;
    res_t out_res;

    mtt_front #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    mtt_engine #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {(OUT_DATA_W - TAG_W - SLOT_W)'(0), out_res.tag, out_res.slot};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

endmodule

>>> tb/tb_multi_timer_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_multi_timer_table_core: self-checking bench for the timer table
// Drives start, cancel, tick and unknown commands over the input stream with
// random gaps. A local copy of the timer table predicts every result beat.
// The output stream sees random back pressure and one long hold-off. Each
// result beat is checked field by field against the oldest predicted beat.
// ============================================================================
module tb_multi_timer_table_core;
    import mtt_pkg::*;

    localparam int               TIMERS      = NUM_TIMERS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int               CYCLE_LIMIT = 1000000;
    localparam int               DRAIN_CYCLES = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // duration, user_tag, slot_number, pad
    logic [CMD_W-1:0]      s_tuser;   // cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // slot, tag_out, pad
    logic [STATUS_W-1:0]   m_tuser;   // status
    logic                  m_tlast;

    logic [DUR_W-1:0] timer_remaining [TIMERS];
    logic [TAG_W-1:0] timer_tag [TIMERS];
    bit               timer_active [TIMERS];
    res_t             expected_results [$];

    int error_count;
    int cycle_count;
    bit no_idle;
    int hold_request;
    int hold_left;

    multi_timer_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d beats still expected", $time,
                     expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random back pressure, or a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 30);
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual status %0d slot %0d",
                         $time, m_tuser, m_tdata[SLOT_W-1:0]);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("status", 32'(want.status), 32'(m_tuser));
                report_field("slot", 32'(want.slot), 32'(m_tdata[SLOT_W-1:0]));
                report_field("tag_out", want.tag, m_tdata[SLOT_W +: TAG_W]);
                report_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    function automatic void push_result(input status_t status, input int slot,
                                        input logic [TAG_W-1:0] tag, input logic last);
        res_t r;
        r.status = status;
        r.slot   = slot[SLOT_W-1:0];
        r.tag    = tag;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_timer_table(input logic [CMD_W-1:0] cmd,
                                                input logic [DUR_W-1:0] dur,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [SLOT_NUM_W-1:0] num);
        int free_slot;
        free_slot = -1;
        case (cmd)
            CMD_START:
            begin
                for (int i = TIMERS - 1; i >= 0; i--)
                    if (!timer_active[i])
                        free_slot = i;
                if (dur == 0)
                    push_result(ST_INVALID, 0, '0, 1'b1);
                else if (free_slot < 0)
                    push_result(ST_FULL, 0, '0, 1'b1);
                else
                begin
                    timer_remaining[free_slot] = dur;
                    timer_tag[free_slot]       = tag;
                    timer_active[free_slot]    = 1'b1;
                    push_result(ST_OK, free_slot, '0, 1'b1);
                end
            end
            CMD_CANCEL:
            begin
                if (num >= TIMERS)
                    push_result(ST_INVALID, 0, '0, 1'b1);
                else if (!timer_active[num])
                    push_result(ST_NOT_ACTIVE, 0, '0, 1'b1);
                else
                begin
                    timer_remaining[num] = '0;
                    timer_tag[num]       = '0;
                    timer_active[num]    = 1'b0;
                    push_result(ST_OK, int'(num), '0, 1'b1);
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < TIMERS; i++)
                begin
                    if (timer_active[i])
                    begin
                        if (timer_remaining[i] != 0)
                            timer_remaining[i] = timer_remaining[i] - 1'b1;
                        if (timer_remaining[i] == 0)
                        begin
                            push_result(ST_EXPIRED, i, timer_tag[i], 1'b0);
                            timer_active[i] = 1'b0;
                        end
                    end
                end
                push_result(ST_TICK_DONE, 0, '0, 1'b1);
            end
            default:
                push_result(ST_INVALID, 0, '0, 1'b1);
        endcase
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DUR_W-1:0] dur,
                                input logic [TAG_W-1:0] tag,
                                input logic [SLOT_NUM_W-1:0] num);
        while (!no_idle && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, num, tag, dur};
        do
            @(posedge clk);
        while (!s_tready);
        predict_timer_table(cmd, dur, tag, num);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int count_active();
        int n;
        n = 0;
        for (int i = 0; i < TIMERS; i++)
            n += timer_active[i];
        return n;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 60)
            return DUR_W'($urandom_range(4, 1));
        if (r < 85)
            return DUR_W'($urandom_range(20, 5));
        return DUR_W'($urandom_range(65535));
    endfunction

    function automatic logic [SLOT_NUM_W-1:0] pick_cancel_slot();
        int live [$];
        for (int i = 0; i < TIMERS; i++)
            if (timer_active[i])
                live.push_back(i);
        if (live.size() != 0 && $urandom_range(99) < 65)
            return SLOT_NUM_W'(live[$urandom_range(live.size() - 1)]);
        return SLOT_NUM_W'($urandom_range(63));
    endfunction

    task automatic send_random_command();
        int r;
        r = $urandom_range(99);
        if (r < 42)
            send_command(CMD_START, pick_duration(), $urandom(), SLOT_NUM_W'($urandom()));
        else if (r < 70)
            send_command(CMD_TICK, DUR_W'($urandom()), $urandom(), SLOT_NUM_W'($urandom()));
        else if (r < 95)
            send_command(CMD_CANCEL, DUR_W'($urandom()), $urandom(), pick_cancel_slot());
        else
            send_command(CMD_UNKNOWN, DUR_W'($urandom()), $urandom(), SLOT_NUM_W'($urandom()));
    endtask

    task automatic test_directed();
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_START, '0, 32'h1234_5678, '0);
        send_command(CMD_CANCEL, '0, '0, 6'd0);
        send_command(CMD_CANCEL, '0, '0, 6'd32);
        send_command(CMD_CANCEL, '1, '1, 6'd63);
        send_command(CMD_UNKNOWN, 16'd5, 32'hDEAD_BEEF, 6'd3);
        send_command(CMD_START, 16'd1, 32'hFFFF_FFFF, '0);
        send_command(CMD_START, 16'hFFFF, 32'h0000_0000, 6'h3F);
        send_command(CMD_START, 16'd2, 32'hA5A5_5A5A, '0);
        send_command(CMD_CANCEL, '0, '0, 6'd1);
        send_command(CMD_CANCEL, '0, '0, 6'd1);
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_START, 16'd3, 32'h0F0F_F0F0, '0);
        send_command(CMD_START, 16'hFFFF, 32'h8000_0001, '0);
        send_command(CMD_CANCEL, '0, '0, 6'd31);
        send_command(CMD_CANCEL, '0, '0, 6'd1);
        send_command(CMD_TICK, '0, '0, '0);
        wait_drained();
    endtask

    // fill every slot with a one-tick timer so that one tick expires all of them
    task automatic test_table_full();
        while (count_active() != 0)
            send_command(CMD_TICK, '0, '0, '0);
        for (int i = 0; i < TIMERS; i++)
            send_command(CMD_START, 16'd1, $urandom(), '0);
        send_command(CMD_START, 16'd7, $urandom(), '0);
        send_command(CMD_START, 16'hFFFF, $urandom(), '0);
        send_command(CMD_CANCEL, '0, '0, 6'd31);
        send_command(CMD_START, 16'd1, $urandom(), '0);
        send_command(CMD_TICK, '0, '0, '0);
        send_command(CMD_TICK, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 400; n++)
        begin
            no_idle = (n >= 150 && n < 230);
            send_random_command();
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // hold the output stream while commands keep coming, so the queue fills
    task automatic test_output_hold();
        hold_request = 400;
        for (int n = 0; n < 20; n++)
        begin
            if (n % 4 == 3)
                send_command(CMD_TICK, '0, '0, '0);
            else
                send_command(CMD_START, DUR_W'($urandom_range(3, 1)), $urandom(), '0);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        error_count  = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        hold_request = 0;
        hold_left    = 0;
        for (int i = 0; i < TIMERS; i++)
        begin
            timer_remaining[i] = '0;
            timer_tag[i]       = '0;
            timer_active[i]    = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_full();
        test_random_mix();
        test_output_hold();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
